// ===== rtl/sllm_pkg.sv =====
// shared constants, types and helpers for the static linked list manager
`timescale 1ns / 1ps
`default_nettype none

package sllm_pkg;

  localparam int CAPACITY = 16;
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam link_t NIL_LINK = link_t'(CAPACITY);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  function automatic logic is_node(input link_t l);
    return l < NIL_LINK;
  endfunction

  // link held by a node that was never written since reset
  function automatic link_t reset_link(input idx_t i);
    if (LINK_W'(i) == link_t'(CAPACITY - 1)) begin
      return NIL_LINK;
    end
    return LINK_W'(i) + link_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/static_linked_list_manager_core.sv =====
// static linked list manager: node store, free list and command sequencer
//
// usage: present command, value and position with start high while busy is
// low; the command is taken at that clock edge and busy rises until all of
// its results are out, unless it answers at once with full, bad position
// or empty status. each result shows on status, item_value and last for
// one cycle with valid high; last marks the final result of a command. the
// receiver cannot hold results off, and none is needed: at most one result
// leaves per cycle. outcome by command:
//   append: full when no node is free, else ok after a walk to the tail
//   delete: bad position when negative, ok when found, else not found
//   list:   empty when the list is empty, else one element per cycle
// every step is one read of the link store, whose read data is registered.
// busy falls in the cycle the last result is shown, so the next command
// may be taken then. command code 3 is dropped.
// reset chains all nodes into the free list at once through per-node
// written flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module static_linked_list_manager_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] value,
  input  wire logic signed [7:0]  position,
  output logic                    valid,
  output logic [2:0]              status,
  output logic signed [31:0]      item_value,
  output logic                    last
);
  import sllm_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_AP_FREE = 3'd1;
  localparam logic [2:0] S_AP_WALK = 3'd2;
  localparam logic [2:0] S_DL_WALK = 3'd3;
  localparam logic [2:0] S_DL_FREE = 3'd4;
  localparam logic [2:0] S_RD_WALK = 3'd5;

  // node store
  link_t               link_mem [CAPACITY];
  logic [31:0]         value_mem [CAPACITY];
  logic [CAPACITY-1:0] written;

  link_t       link_rd;
  logic        written_rd;
  idx_t        idx_rd;
  logic [31:0] value_rd;
  link_t       link_q;

  // control state
  logic [2:0]  state;
  link_t       free_head;
  link_t       list_head;
  link_t       cur;
  link_t       prev;
  link_t       node;
  link_t       steps;
  logic [6:0]  pos;
  logic [31:0] val;

  idx_t        rd_addr;
  logic        link_we;
  idx_t        link_wa;
  link_t       link_wd;
  logic        ap_stop;

  assign busy   = (state != S_IDLE);
  assign link_q = written_rd ? link_rd : reset_link(idx_rd);
  assign ap_stop = (steps == link_t'(CAPACITY)) || !is_node(link_q);

  always_comb begin
    rd_addr = cur[IDX_W-1:0];
    link_we = 1'b0;
    link_wa = cur[IDX_W-1:0];
    link_wd = NIL_LINK;
    unique case (state)
      S_IDLE: begin
        rd_addr = (command == CMD_APPEND) ? free_head[IDX_W-1:0] : list_head[IDX_W-1:0];
      end
      S_AP_FREE: begin
        rd_addr = list_head[IDX_W-1:0];
        link_we = 1'b1;
        link_wa = node[IDX_W-1:0];
        link_wd = NIL_LINK;
      end
      S_AP_WALK: begin
        rd_addr = link_q[IDX_W-1:0];
        link_we = ap_stop;
        link_wa = cur[IDX_W-1:0];
        link_wd = node;
      end
      S_DL_WALK: begin
        rd_addr = link_q[IDX_W-1:0];
        link_we = is_node(cur) && (7'(steps) == pos) && is_node(prev);
        link_wa = prev[IDX_W-1:0];
        link_wd = link_q;
      end
      S_DL_FREE: begin
        link_we = 1'b1;
        link_wa = cur[IDX_W-1:0];
        link_wd = free_head;
      end
      S_RD_WALK: begin
        rd_addr = link_q[IDX_W-1:0];
      end
      default: begin
        rd_addr = cur[IDX_W-1:0];
      end
    endcase
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (state == S_AP_FREE) begin
      value_mem[node[IDX_W-1:0]] <= val;
    end
    link_rd    <= link_mem[rd_addr];
    value_rd   <= value_mem[rd_addr];
    written_rd <= written[rd_addr];
    idx_rd     <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (link_we) begin
      written[link_wa] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      list_head <= NIL_LINK;
      valid     <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val   <= value;
            pos   <= position[6:0];
            steps <= '0;
            prev  <= NIL_LINK;
            case (command)
              CMD_APPEND: begin
                node <= free_head;
                if (!is_node(free_head)) begin
                  valid      <= 1'b1;
                  status     <= ST_FULL;
                  item_value <= '0;
                  last       <= 1'b1;
                end else begin
                  cur   <= free_head;
                  state <= S_AP_FREE;
                end
              end
              CMD_DELETE: begin
                cur <= list_head;
                if (position[7]) begin
                  valid      <= 1'b1;
                  status     <= ST_BAD_POS;
                  item_value <= '0;
                  last       <= 1'b1;
                end else begin
                  state <= S_DL_WALK;
                end
              end
              CMD_LIST: begin
                cur <= list_head;
                if (!is_node(list_head)) begin
                  valid      <= 1'b1;
                  status     <= ST_EMPTY;
                  item_value <= '0;
                  last       <= 1'b1;
                end else begin
                  state <= S_RD_WALK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_AP_FREE: begin
          free_head <= link_q;
          if (!is_node(list_head)) begin
            list_head  <= node;
            valid      <= 1'b1;
            status     <= ST_OK;
            item_value <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            cur   <= list_head;
            state <= S_AP_WALK;
          end
        end
        S_AP_WALK: begin
          if (ap_stop) begin
            valid      <= 1'b1;
            status     <= ST_OK;
            item_value <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            cur   <= link_q;
            steps <= steps + link_t'(1);
          end
        end
        S_DL_WALK: begin
          if (!is_node(cur)) begin
            valid      <= 1'b1;
            status     <= ST_NOT_FOUND;
            item_value <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else if (7'(steps) == pos) begin
            if (!is_node(prev)) begin
              list_head <= link_q;
            end
            state <= S_DL_FREE;
          end else begin
            prev  <= cur;
            cur   <= link_q;
            steps <= steps + link_t'(1);
          end
        end
        S_DL_FREE: begin
          free_head  <= cur;
          valid      <= 1'b1;
          status     <= ST_OK;
          item_value <= '0;
          last       <= 1'b1;
          state      <= S_IDLE;
        end
        S_RD_WALK: begin
          valid      <= 1'b1;
          status     <= ST_OK;
          item_value <= value_rd;
          if (!is_node(link_q) || (steps == link_t'(CAPACITY - 1))) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end else begin
            last  <= 1'b0;
            cur   <= link_q;
            steps <= steps + link_t'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
